// ----- hdl/acrr_pkg.sv -----
// Shared types and constants for the aging channel round robin.
package acrr_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int IDX_W        = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
	localparam int CHAN_W       = 8;
	localparam int TIME_W       = 32;
	localparam int USED_W       = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;

	localparam logic OP_NOTE_USE = 1'b0;
	localparam logic OP_ROTATE   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_AGE_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CHANNEL = 1'd1;

	localparam logic [TIME_W-1:0] AGE_TIMEOUT_RST   = 32'd2000;
	localparam logic [CHAN_W-1:0] START_CHANNEL_RST = 8'd1;

	typedef struct packed {
		logic              op;
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] current_channel;
		logic              switched;
		logic              table_full;
		logic [USED_W-1:0] entries_used;
	} rsp_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] last_use;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/acrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module acrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/aging_channel_round_robin.sv -----
// Top level: channel table with aging, kept in one RAM and walked by a sequencer.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  req_t: op, channel, now
//  rsp      out  rsp_valid/rsp_stall  rsp_t: current_channel, switched, table_full, entries_used
//  cfg      in   cfg_valid/cfg_ready  cfg_index (0 age_timeout, 1 start_channel), cfg_data
//
// One request in work at a time; one RAM read per cycle, its data in the next cycle.
// note_use: lookup, then the response is loaded, then back to idle.
// rotate: lookup, circular pass, compaction (only when an entry aged out), then the
// response is loaded and the block goes back to idle.
// Reset clears control state and the entry count; RAM entries above the count are never read.
// A stalled response holds; the next request is still taken and worked, its hand-off waits.
module aging_channel_round_robin (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  acrr_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output acrr_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [acrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [acrr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import acrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_PASS,
		S_COMPACT,
		S_DONE
	} state_t;

	state_t              state_q;
	req_t                req_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic [TIME_W-1:0]   age_timeout_q;
	logic [CHAN_W-1:0]   active_q;
	logic [CHAN_W-1:0]   old_q;
	logic [CNT_W-1:0]    count_q;
	logic                full_q;
	logic                removed_q;
	logic [MAX_CHANNELS-1:0] keep_q;
	logic [IDX_W-1:0]    start_q;
	logic [CNT_W-1:0]    scan_q;   // next read: entry index, or step k during the pass
	logic [CNT_W-1:0]    wr_q;     // compaction write pointer
	logic                rdv_s1;   // read data arrives this cycle
	logic [IDX_W-1:0]    ridx_s1;  // entry index of the arriving data
	logic [CNT_W-1:0]    rk_s1;    // pass step of the arriving data

	logic                issue;
	logic [CNT_W:0]      pos_sum;
	logic [CNT_W:0]      pos_wrap;
	logic [IDX_W-1:0]    rd_addr;
	entry_t              rd_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic [CHAN_W-1:0]   target;
	logic                match;
	logic [TIME_W-1:0]   age;
	logic                stale;
	logic                last_idx;
	logic                last_step;
	logic                not_found;
	logic                room;
	logic                rsp_free;

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Issue one read per cycle while entries remain in the current walk.
	assign issue = ((state_q == S_FIND) || (state_q == S_PASS) || (state_q == S_COMPACT))
		&& (scan_q < count_q);

	// Circular position start + k, folded back into the table.
	assign pos_sum  = (CNT_W+1)'(start_q) + (CNT_W+1)'(scan_q);
	assign pos_wrap = (pos_sum >= {1'b0, count_q}) ? pos_sum - {1'b0, count_q} : pos_sum;
	assign rd_addr  = (state_q == S_PASS) ? pos_wrap[IDX_W-1:0] : scan_q[IDX_W-1:0];

	assign target    = (req_q.op == OP_NOTE_USE) ? req_q.channel : active_q;
	assign match     = (rd_data.channel == target);
	assign age       = req_q.now - rd_data.last_use;
	assign stale     = (age > age_timeout_q);
	assign last_idx  = (CNT_W'(ridx_s1) == count_q - CNT_W'(1));
	assign last_step = (rk_s1 == count_q - CNT_W'(1));
	assign not_found = (count_q == '0) || (rdv_s1 && !match && last_idx);
	assign room      = (count_q < CNT_W'(MAX_CHANNELS));

	// RAM write: refresh or append on note_use, move kept entries down on compaction.
	// Compaction writes at or below the entry just read and reads run ahead, so no
	// read ever meets a pending write to the same entry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ridx_s1;
		wr_data = '{channel: req_q.channel, last_use: req_q.now};
		unique case (state_q)
			S_FIND: begin
				if (req_q.op == OP_NOTE_USE) begin
					if (rdv_s1 && match) begin
						wr_en = 1'b1;
					end else if (not_found && room) begin
						wr_en   = 1'b1;
						wr_addr = count_q[IDX_W-1:0];
					end
				end
			end
			S_COMPACT: begin
				if (rdv_s1 && keep_q[ridx_s1]) begin
					wr_en   = 1'b1;
					wr_addr = wr_q[IDX_W-1:0];
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	acrr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CHANNELS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
			age_timeout_q <= AGE_TIMEOUT_RST;
			active_q      <= START_CHANNEL_RST;
			old_q         <= '0;
			count_q       <= '0;
			full_q        <= 1'b0;
			removed_q     <= 1'b0;
			keep_q        <= '1;
			start_q       <= '0;
			scan_q        <= '0;
			wr_q          <= '0;
			rdv_s1        <= 1'b0;
			ridx_s1       <= '0;
			rk_s1         <= '0;
		end else begin
			// Drain the output register.
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// Track the read pipeline by default.
			rdv_s1  <= issue;
			ridx_s1 <= rd_addr;
			rk_s1   <= scan_q;
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q     <= req;
						old_q     <= active_q;
						full_q    <= 1'b0;
						removed_q <= 1'b0;
						keep_q    <= '1;
						scan_q    <= '0;
						wr_q      <= '0;
						// A rotate over fewer than two entries changes nothing.
						if (req.op == OP_ROTATE && count_q < CNT_W'(2)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (rdv_s1 && match) begin
						if (req_q.op == OP_NOTE_USE) begin
							state_q <= S_DONE;
						end else begin
							// Start the circular pass just after the current entry.
							start_q <= ridx_s1;
							scan_q  <= CNT_W'(1);
							rdv_s1  <= 1'b0;
							state_q <= S_PASS;
						end
					end else if (not_found) begin
						if (req_q.op == OP_NOTE_USE) begin
							if (room) begin
								count_q <= count_q + CNT_W'(1);
							end else begin
								full_q <= 1'b1;
							end
						end
						// A rotate whose current channel is absent keeps the table.
						state_q <= S_DONE;
					end
				end
				S_PASS: begin
					if (rdv_s1) begin
						if (stale) begin
							keep_q[ridx_s1] <= 1'b0;
							removed_q       <= 1'b1;
							if (last_step) begin
								scan_q  <= '0;
								rdv_s1  <= 1'b0;
								state_q <= S_COMPACT;
							end
						end else begin
							// First fresh entry becomes current; compact only if needed.
							active_q <= rd_data.channel;
							scan_q   <= '0;
							rdv_s1   <= 1'b0;
							state_q  <= removed_q ? S_COMPACT : S_DONE;
						end
					end else if (!issue) begin
						// Pass over with nothing left to read.
						scan_q  <= '0;
						state_q <= removed_q ? S_COMPACT : S_DONE;
					end
				end
				S_COMPACT: begin
					if (rdv_s1) begin
						if (keep_q[ridx_s1]) begin
							wr_q <= wr_q + CNT_W'(1);
						end
						if (last_idx) begin
							count_q <= wr_q + CNT_W'(keep_q[ridx_s1]);
							rdv_s1  <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q          <= 1'b1;
						rsp_q.current_channel <= active_q;
						rsp_q.switched       <= (active_q != old_q);
						rsp_q.table_full     <= full_q;
						rsp_q.entries_used   <= USED_W'(count_q);
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// The user must send register writes only while no request is in work; the block does not enforce this.
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_AGE_TIMEOUT: begin
						age_timeout_q <= cfg_data[TIME_W-1:0];
					end
					REG_START_CHANNEL: begin
						active_q <= cfg_data[CHAN_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- hdl/acrr_checker.sv -----
// Port-level checks for the aging channel round robin, bound to the top level.
module acrr_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input acrr_pkg::rsp_t        rsp
);
	import acrr_pkg::*;

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one request is in work: an accepted request blocks the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// A full table never goes with a channel switch.
	a_full_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.table_full && rsp.switched))
		else $error("table_full and switched both set");

	// Full is reported only with every entry taken.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |-> rsp.entries_used == USED_W'(MAX_CHANNELS))
		else $error("table_full with free entries");

endmodule

bind aging_channel_round_robin acrr_checker u_acrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
